/* src/smd_pkg.sv */
// Shared types and constants for the segmentation mask decider.
package smd_pkg;

  localparam int MAX_CLASSES = 32;

  localparam logic [1:0] MODE_ARGMAX  = 2'd0;
  localparam logic [1:0] MODE_THRESH  = 2'd1;
  localparam logic [1:0] MODE_TWO_CH  = 2'd2;
  localparam logic [1:0] MODE_NONE    = 2'd3;

  localparam logic [1:0] REG_MODE     = 2'd0;
  localparam logic [1:0] REG_PERSON   = 2'd1;
  localparam logic [1:0] REG_THRESH   = 2'd2;

  localparam logic signed [15:0] Q88_MIN       = 16'sh8000;
  localparam logic signed [15:0] THRESH_RESET  = 16'sd166;
  localparam logic [4:0]         PERSON_RESET  = 5'd15;

  typedef struct packed {
    logic [15:0]        pixel_index;
    logic [4:0]         class_index;
    logic signed [15:0] score;
    logic               last;
  } in_t;

  typedef struct packed {
    logic [15:0] out_pixel;
    logic [7:0]  mask_value;
    logic        is_person;
  } out_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [4:0]         person_class;
    logic signed [15:0] threshold;
  } cfg_t;

  typedef struct packed {
    logic decide;
    logic person;
  } decision_t;

endpackage

/* src/smd_stream_if.sv */
// Valid/ready stream interface carrying one payload item per transfer.
interface smd_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* src/segmentation_mask_decider.sv */
// Top level: score stream in, mask store read-modify-write, mask result stream out.
//
//   channel   dir  payload                                 transfer
//   scores    in   pixel_index, class_index, score, last   valid && ready
//   results   out  out_pixel, mask_value, is_person        valid && ready
//   cfg       in   cfg_index, cfg_data                     cfg_we
//
// One score per cycle sustained while the output does not stall and no clear is running;
// a decided pixel passes the mask store read, then the modify/write into the output register.
// After reset the mask store is cleared one entry a cycle, all min(MASK_PIXELS, 65536)
// entries, with scores.ready low; config writes are taken meanwhile. A stalled output
// holds the result and the pipeline stage behind it; scores.ready drops while it is full.
module segmentation_mask_decider
  import smd_pkg::*;
#(
  parameter int MASK_PIXELS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  smd_stream_if.sink   scores,
  smd_stream_if.source results
);

  localparam int DEPTH = (MASK_PIXELS < 65536) ? MASK_PIXELS : 65536;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t      cfg;
  decision_t dec;
  in_t       item;

  logic          clearing;
  logic [AW-1:0] clr_cnt;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;

  logic          s1_valid;
  logic [15:0]   s1_pixel;
  logic          s1_person;
  logic          s1_fwd;
  logic [7:0]    s1_fwd_data;
  logic [7:0]    s1_old;
  logic [7:0]    s1_newv;
  logic          s1_adv;
  logic          in_ready;
  logic          fire;
  logic          in_range;
  logic          out_valid;
  out_t          out_data;

  assign item     = scores.data;
  assign s1_adv   = !out_valid || results.ready;
  assign in_ready = !clearing && (!s1_valid || s1_adv);
  assign fire     = scores.valid && in_ready;
  assign in_range = 32'(item.pixel_index) < MASK_PIXELS;
  assign s1_old   = s1_fwd ? s1_fwd_data : rdata;
  assign s1_newv  = {{3{~s1_person}}, s1_old[7:3]};

  assign scores.ready  = in_ready;
  assign results.valid = out_valid;
  assign results.data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_ARGMAX;
      cfg.person_class <= PERSON_RESET;
      cfg.threshold    <= THRESH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:   cfg.mode         <= cfg_data[1:0];
        REG_PERSON: cfg.person_class <= cfg_data[4:0];
        REG_THRESH: cfg.threshold    <= cfg_data;
        default: ;
      endcase
    end
  end

  smd_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (fire),
    .item (item),
    .dec  (dec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      if (clr_cnt == AW'(DEPTH - 1)) clearing <= 1'b0;
      else clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt] <= 8'd0;
    end else if (s1_valid && s1_adv) begin
      mem[s1_pixel[AW-1:0]] <= s1_newv;
    end
    if (fire) rdata <= mem[item.pixel_index[AW-1:0]];
  end

  // forward the write that lands on the same edge as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= fire && dec.decide && in_range;
    end
    if (fire) begin
      s1_pixel    <= item.pixel_index;
      s1_person   <= dec.person;
      s1_fwd      <= s1_valid && s1_adv && (s1_pixel == item.pixel_index);
      s1_fwd_data <= s1_newv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= s1_valid;
    end
    if (s1_adv && s1_valid) begin
      out_data.out_pixel  <= s1_pixel;
      out_data.mask_value <= s1_newv;
      out_data.is_person  <= s1_person;
    end
  end

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !scores.ready)
    else $error("score accepted during mask clear");

  a_value_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_person ? (out_data.mask_value[7:5] == 3'b000)
                                      : (out_data.mask_value[7:5] == 3'b111)))
    else $error("mask value bits disagree with decision");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_adv) |=> (s1_valid && $stable(s1_pixel)))
    else $error("stalled pixel lost from modify stage");

  a_result_enters: assert property (@(posedge clk) disable iff (rst)
    (fire && dec.decide && in_range) |=> s1_valid)
    else $error("decided pixel did not enter modify stage");

endmodule

/* src/smd_tracker.sv */
// Running argmax and background tracking with the per-pixel decision.
module smd_tracker
  import smd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      fire,
  input  in_t       item,
  output decision_t dec
);

  logic signed [15:0] best_score;
  logic [4:0]         best_class;
  logic signed [15:0] background_score;

  logic               cls_zero;
  logic signed [15:0] base_score;
  logic [4:0]         base_class;
  logic signed [15:0] bg_next;
  logic               take;
  logic signed [15:0] best_score_next;
  logic [4:0]         best_class_next;

  always_comb begin
    cls_zero        = (item.class_index == 5'd0);
    base_score      = cls_zero ? Q88_MIN : best_score;
    base_class      = cls_zero ? 5'd0 : best_class;
    bg_next         = cls_zero ? item.score : background_score;
    take            = (32'(item.class_index) < MAX_CLASSES) && (item.score > base_score);
    best_score_next = take ? item.score : base_score;
    best_class_next = take ? item.class_index : base_class;

    dec.decide = item.last && (cfg.mode != MODE_NONE);
    case (cfg.mode)
      MODE_ARGMAX: dec.person = (best_class_next == cfg.person_class);
      MODE_THRESH: dec.person = (item.score > cfg.threshold);
      MODE_TWO_CH: dec.person = (item.score > bg_next);
      default:     dec.person = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      best_score       <= Q88_MIN;
      best_class       <= 5'd0;
      background_score <= 16'sd0;
    end else if (fire) begin
      background_score <= bg_next;
      if (item.last) begin
        best_score <= Q88_MIN;
        best_class <= 5'd0;
      end else begin
        best_score <= best_score_next;
        best_class <= best_class_next;
      end
    end
  end

endmodule
